// ===== rtl/pms_pkg.sv =====
`timescale 1ns / 1ps
package pms_pkg;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED     = 3'd0,
    CFG_MIN_SPEED     = 3'd1,
    CFG_DECAY_FACTOR  = 3'd2,
    CFG_PULL_RADIUS   = 3'd3,
    CFG_PULL_STRENGTH = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    FUNC_SPAWN = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef enum logic [5:0] {
    S_IDLE, S_VEL, S_SQX, S_SQY, S_SQMAX, S_SQMIN, S_CMP, S_LEN,
    S_RMX, S_RDX, S_RWX, S_RMY, S_RDY, S_RWY,
    S_MOVE, S_DVX, S_DVY, S_DAX, S_DAY, S_DST, S_PSY, S_PSQ, S_DIST,
    S_PM, S_PMW, S_PCX, S_PDX, S_PWX, S_PCY, S_PDY, S_PWY,
    S_AGE, S_DONE
  } state_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_QBITS  = 34;

  localparam logic signed [35:0] S36_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S36_MIN = -36'sd2147483648;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic signed [35:0] ext36(logic signed [31:0] v);
    return signed'({{4{v[31]}}, v});
  endfunction

  function automatic logic signed [35:0] apply_sign(logic neg, logic [33:0] m);
    logic signed [35:0] t;
    t = signed'({2'b00, m});
    return neg ? -t : t;
  endfunction

  function automatic logic signed [31:0] sat36(logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > S36_MAX) r = 32'sh7FFFFFFF;
    else if (v < S36_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/pms_in_if.sv =====
`timescale 1ns / 1ps
interface pms_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] spawn_pos_x;
  logic signed [31:0] spawn_pos_y;
  logic signed [31:0] spawn_vel_x;
  logic signed [31:0] spawn_vel_y;
  logic [15:0]        spawn_life;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;

  modport source (output valid, func, spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y,
                  spawn_life, push_x, push_y, input ready);
  modport sink (input valid, func, spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y,
                spawn_life, push_x, push_y, output ready);
endinterface

// ===== rtl/pms_out_if.sv =====
`timescale 1ns / 1ps
interface pms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               expired;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, expired, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, expired, output ready);
endinterface

// ===== rtl/pms_sqrt.sv =====
`timescale 1ns / 1ps
module pms_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         radicand,
  output logic [31:0]         root,
  output pms_pkg::unit_stat_t stat
);
  import pms_pkg::*;

  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [35:0] r2, trial;

  // one result bit per cycle, two radicand bits consumed
  always_comb begin
    r2       = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 6'(SQRT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (r2 >= trial) begin
        rem_nxt  = 34'(r2 - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = r2[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/pms_div.sv =====
`timescale 1ns / 1ps
module pms_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  output logic [33:0]         quotient,
  output pms_pkg::unit_stat_t stat
);
  import pms_pkg::*;

  // quotient fits in 34 bits for every use, so the top of the dividend
  // starts below the divisor
  logic [31:0] rem_r, rem_nxt;
  logic [33:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] t;

  always_comb begin
    t        = {rem_r, quo_r[33]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {2'b00, dividend[63:34]};
      quo_nxt  = dividend[33:0];
      dvs_nxt  = divisor;
      cnt_nxt  = 6'(DIV_QBITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(t - {1'b0, dvs_r});
        quo_nxt = {quo_r[32:0], 1'b1};
      end else begin
        rem_nxt = t[31:0];
        quo_nxt = {quo_r[32:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/particle_motion_step_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Word
// in_ch    in   valid/ready        func, spawn values, push_x/y
// out_ch   out  valid/ready        pos_x/y, vel_x/y, expired
// cfg_*    in   cfg_we, no stall   cfg_idx selects register, cfg_data
//
// Spawn word: goes from idle straight to the final load state. Step word: the
// path is shortest with no speed clamp and no center pull and longest with both,
// set by the square root unit (up to two uses) and divider (up to four uses).
// Reset: synchronous on rst_n low; state, particle and config registers reset.
// in_ch.ready is high only while the sequencer sits idle; a held result in the
// output register stalls only the final load, not the next accept.
module particle_motion_step_unit (
  input  logic         clk,
  input  logic         rst_n,
  pms_in_if.sink       in_ch,
  pms_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [30:0]  cfg_data
);
  import pms_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [30:0] max_spd_r, min_spd_r, pull_rad_r;
  logic [16:0] decay_r, pull_str_r;

  // particle state
  logic signed [31:0] px_r, py_r, vx_r, vy_r, ax_r, ay_r;
  logic signed [31:0] px_nxt, py_nxt, vx_nxt, vy_nxt, ax_nxt, ay_nxt;
  logic [15:0] age_r, age_nxt, life_r, life_nxt;
  logic        dead_r, dead_nxt;

  // working registers
  logic [63:0] prod_r, sum_r, sum_nxt;
  logic        gt_r, gt_nxt;
  logic [30:0] lim_r, lim_nxt;
  logic [31:0] len_r, len_nxt;
  logic [33:0] m_r, m_nxt;

  // shared multiplier
  logic [31:0] mul_a;
  logic [33:0] mul_b;
  logic [65:0] mul_p;

  // output register
  logic               out_valid_r, out_valid_nxt, out_load;
  logic signed [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r;
  logic               o_exp_r;

  // iterative units
  logic        sq_start, dv_start;
  logic [63:0] sq_rad, dv_num;
  logic [31:0] sq_root;
  logic [33:0] dv_q;
  unit_stat_t  sq_st, dv_st;

  logic in_acc;
  logic [15:0] age_inc;

  assign in_acc = in_ch.valid && in_ch.ready;

  pms_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .radicand(sq_rad), .root(sq_root), .stat(sq_st)
  );

  pms_div u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_num), .divisor(len_r),
    .quotient(dv_q), .stat(dv_st)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spd_r  <= 31'd655360;
      min_spd_r  <= 31'd65536;
      decay_r    <= 17'd64880;
      pull_rad_r <= 31'd13107200;
      pull_str_r <= 17'd66;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_SPEED:     max_spd_r  <= cfg_data;
        CFG_MIN_SPEED:     min_spd_r  <= cfg_data;
        CFG_DECAY_FACTOR:  decay_r    <= cfg_data[16:0];
        CFG_PULL_RADIUS:   pull_rad_r <= cfg_data;
        CFG_PULL_STRENGTH: pull_str_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // pick multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX:   begin mul_a = mag32(vx_r);          mul_b = {2'b00, mag32(vx_r)};   end
      S_SQY:   begin mul_a = mag32(vy_r);          mul_b = {2'b00, mag32(vy_r)};   end
      S_SQMAX: begin mul_a = {1'b0, max_spd_r};    mul_b = {3'b000, max_spd_r};    end
      S_SQMIN: begin mul_a = {1'b0, min_spd_r};    mul_b = {3'b000, min_spd_r};    end
      S_RMX:   begin mul_a = mag32(vx_r);          mul_b = {3'b000, lim_r};        end
      S_RMY:   begin mul_a = mag32(vy_r);          mul_b = {3'b000, lim_r};        end
      S_DVX:   begin mul_a = mag32(vx_r);          mul_b = {17'd0, decay_r};       end
      S_DVY:   begin mul_a = mag32(vy_r);          mul_b = {17'd0, decay_r};       end
      S_DAX:   begin mul_a = mag32(ax_r);          mul_b = {17'd0, decay_r};       end
      S_DAY:   begin mul_a = mag32(ay_r);          mul_b = {17'd0, decay_r};       end
      S_DST:   begin mul_a = mag32(px_r);          mul_b = {2'b00, mag32(px_r)};   end
      S_PSY:   begin mul_a = mag32(py_r);          mul_b = {2'b00, mag32(py_r)};   end
      S_PM:    begin mul_a = len_r - {1'b0, pull_rad_r}; mul_b = {17'd0, pull_str_r}; end
      S_PCX:   begin mul_a = mag32(px_r);          mul_b = m_r;                    end
      S_PCY:   begin mul_a = mag32(py_r);          mul_b = m_r;                    end
      default: ;
    endcase
  end

  assign mul_p = {34'd0, mul_a} * {32'd0, mul_b};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (in_ch.func == FUNC_SPAWN) ? S_DONE : S_VEL;
      S_VEL:   state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SQMAX;
      S_SQMAX: state_nxt = S_SQMIN;
      S_SQMIN: state_nxt = S_CMP;
      S_CMP:   state_nxt = (gt_r || sum_r < prod_r) ? S_LEN : S_MOVE;
      S_LEN:   if (sq_st.done) state_nxt = (sq_root == 32'd0) ? S_MOVE : S_RMX;
      S_RMX:   state_nxt = S_RDX;
      S_RDX:   state_nxt = S_RWX;
      S_RWX:   if (dv_st.done) state_nxt = S_RMY;
      S_RMY:   state_nxt = S_RDY;
      S_RDY:   state_nxt = S_RWY;
      S_RWY:   if (dv_st.done) state_nxt = S_MOVE;
      S_MOVE:  state_nxt = S_DVX;
      S_DVX:   state_nxt = S_DVY;
      S_DVY:   state_nxt = S_DAX;
      S_DAX:   state_nxt = S_DAY;
      S_DAY:   state_nxt = S_DST;
      S_DST:   state_nxt = S_PSY;
      S_PSY:   state_nxt = S_PSQ;
      S_PSQ:   state_nxt = S_DIST;
      S_DIST:  if (sq_st.done) state_nxt = (sq_root > {1'b0, pull_rad_r}) ? S_PM : S_AGE;
      S_PM:    state_nxt = S_PMW;
      S_PMW:   state_nxt = S_PCX;
      S_PCX:   state_nxt = S_PDX;
      S_PDX:   state_nxt = S_PWX;
      S_PWX:   if (dv_st.done) state_nxt = S_PCY;
      S_PCY:   state_nxt = S_PDY;
      S_PDY:   state_nxt = S_PWY;
      S_PWY:   if (dv_st.done) state_nxt = S_AGE;
      S_AGE:   state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath updates per step
  always_comb begin
    px_nxt = px_r;  py_nxt = py_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;
    age_nxt = age_r; life_nxt = life_r; dead_nxt = dead_r;
    sum_nxt = sum_r; gt_nxt = gt_r; lim_nxt = lim_r; len_nxt = len_r; m_nxt = m_r;
    sq_start = 1'b0; sq_rad = sum_r;
    dv_start = 1'b0; dv_num = prod_r;
    out_load = 1'b0;
    age_inc  = (age_r == 16'hFFFF) ? age_r : age_r + 16'd1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_SPAWN) begin
            px_nxt = in_ch.spawn_pos_x; py_nxt = in_ch.spawn_pos_y;
            vx_nxt = in_ch.spawn_vel_x; vy_nxt = in_ch.spawn_vel_y;
            life_nxt = in_ch.spawn_life;
            ax_nxt = '0; ay_nxt = '0; age_nxt = '0; dead_nxt = 1'b0;
          end else begin
            // add push to acceleration
            ax_nxt = sat36(ext36(ax_r) + ext36(in_ch.push_x));
            ay_nxt = sat36(ext36(ay_r) + ext36(in_ch.push_y));
          end
        end
      end
      S_VEL: begin
        vx_nxt = sat36(ext36(vx_r) + ext36(ax_r));
        vy_nxt = sat36(ext36(vy_r) + ext36(ay_r));
      end
      S_SQY:   sum_nxt = prod_r;
      S_SQMAX: sum_nxt = sum_r + prod_r;
      S_SQMIN: gt_nxt = sum_r > prod_r;
      S_CMP: begin
        // max check wins over min check
        if (gt_r) begin
          lim_nxt  = max_spd_r;
          sq_start = 1'b1;
        end else if (sum_r < prod_r) begin
          lim_nxt  = min_spd_r;
          sq_start = 1'b1;
        end
      end
      S_LEN:  if (sq_st.done) len_nxt = sq_root;
      S_RDX:  dv_start = 1'b1;
      S_RWX:  if (dv_st.done) vx_nxt = sat36(apply_sign(vx_r[31], dv_q));
      S_RDY:  dv_start = 1'b1;
      S_RWY:  if (dv_st.done) vy_nxt = sat36(apply_sign(vy_r[31], dv_q));
      S_MOVE: begin
        px_nxt = sat36(ext36(px_r) + ext36(vx_r));
        py_nxt = sat36(ext36(py_r) + ext36(vy_r));
      end
      S_DVY: vx_nxt = sat36(apply_sign(vx_r[31], prod_r[49:16]));
      S_DAX: vy_nxt = sat36(apply_sign(vy_r[31], prod_r[49:16]));
      S_DAY: ax_nxt = sat36(apply_sign(ax_r[31], prod_r[49:16]));
      S_DST: ay_nxt = sat36(apply_sign(ay_r[31], prod_r[49:16]));
      S_PSY: sum_nxt = prod_r;
      S_PSQ: begin
        sq_rad   = sum_r + prod_r;
        sq_start = 1'b1;
      end
      S_DIST: if (sq_st.done) len_nxt = sq_root;
      S_PMW:  m_nxt = prod_r[49:16];
      S_PDX:  dv_start = 1'b1;
      S_PWX:  if (dv_st.done) ax_nxt = sat36(ext36(ax_r) - apply_sign(px_r[31], dv_q));
      S_PDY:  dv_start = 1'b1;
      S_PWY:  if (dv_st.done) ay_nxt = sat36(ext36(ay_r) - apply_sign(py_r[31], dv_q));
      S_AGE: begin
        age_nxt = age_inc;
        if (age_inc >= life_r) dead_nxt = 1'b1;
      end
      S_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    sum_r  <= sum_nxt;
    gt_r   <= gt_nxt;
    lim_r  <= lim_nxt;
    len_r  <= len_nxt;
    m_r    <= m_nxt;
    if (out_load) begin
      o_px_r  <= px_r;
      o_py_r  <= py_r;
      o_vx_r  <= vx_r;
      o_vy_r  <= vy_r;
      o_exp_r <= dead_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      px_r <= '0; py_r <= '0; vx_r <= '0; vy_r <= '0; ax_r <= '0; ay_r <= '0;
      age_r <= '0; life_r <= '0; dead_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      px_r <= px_nxt; py_r <= py_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
      ax_r <= ax_nxt; ay_r <= ay_nxt;
      age_r <= age_nxt; life_r <= life_nxt; dead_r <= dead_nxt;
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = o_px_r;
  assign out_ch.pos_y   = o_py_r;
  assign out_ch.vel_x   = o_vx_r;
  assign out_ch.vel_y   = o_vy_r;
  assign out_ch.expired = o_exp_r;

  // never restart a unit that is still iterating
  a_sq_start: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_st.busy) else $error("sqrt restarted while busy");
  a_dv_start: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> !dv_st.busy) else $error("divider restarted while busy");
  // an accepted word holds off the next one
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready) else $error("second word accepted during work");
  // spawn clears the expired flag
  a_spawn_live: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_SPAWN) |=> !dead_r) else $error("spawn left flag set");
endmodule

// ===== dv/particle_motion_step_unit_tb.sv =====
`timescale 1ns / 1ps
module particle_motion_step_unit_tb;
  import pms_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               expired;
  } motion_word_t;

  // Scoreboard: a software copy of the particle plus a queue of expected words.
  class particle_scoreboard;
    longint pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    int unsigned age, life;
    bit dead;
    longint unsigned max_spd, min_spd, decay, radius, gain;
    motion_word_t pending[$];
    int mismatches;

    function void reset_state();
      max_spd = 655360; min_spd = 65536; decay = 64880;
      radius = 13107200; gain = 66;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; acc_x = 0; acc_y = 0;
      age = 0; life = 0; dead = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [30:0] d);
      case (idx)
        CFG_MAX_SPEED:     max_spd = d;
        CFG_MIN_SPEED:     min_spd = d;
        CFG_DECAY_FACTOR:  decay = d[16:0];
        CFG_PULL_RADIUS:   radius = d;
        CFG_PULL_STRENGTH: gain = d[16:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned absv(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint signed_as(longint r, longint unsigned m);
      return r < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function longint decayed(longint v);
      return clip(signed_as(v, (absv(v) * decay) >> 16));
    endfunction

    // Scale velocity to the given speed, leaving a zero vector alone.
    function void rescale(longint unsigned lim);
      longint unsigned len;
      len = root(absv(vel_x) * absv(vel_x) + absv(vel_y) * absv(vel_y));
      if (len == 0) return;
      vel_x = clip(signed_as(vel_x, absv(vel_x) * lim / len));
      vel_y = clip(signed_as(vel_y, absv(vel_y) * lim / len));
    endfunction

    function void note_input(func_t f, logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] vx, logic signed [31:0] vy,
                             logic [15:0] lf, logic signed [31:0] ux,
                             logic signed [31:0] uy);
      longint unsigned vsq, span, m, cx, cy;
      motion_word_t w;
      if (f == FUNC_SPAWN) begin
        pos_x = px; pos_y = py; vel_x = vx; vel_y = vy; life = lf;
        acc_x = 0; acc_y = 0; age = 0; dead = 0;
      end else begin
        acc_x = clip(acc_x + ux);
        acc_y = clip(acc_y + uy);
        vel_x = clip(vel_x + acc_x);
        vel_y = clip(vel_y + acc_y);
        vsq = absv(vel_x) * absv(vel_x) + absv(vel_y) * absv(vel_y);
        if (vsq > max_spd * max_spd) rescale(max_spd);
        else if (vsq < min_spd * min_spd) rescale(min_spd);
        pos_x = clip(pos_x + vel_x);
        pos_y = clip(pos_y + vel_y);
        vel_x = decayed(vel_x); vel_y = decayed(vel_y);
        acc_x = decayed(acc_x); acc_y = decayed(acc_y);
        span = root(absv(pos_x) * absv(pos_x) + absv(pos_y) * absv(pos_y));
        if (span > radius) begin
          m = ((span - radius) * gain) >> 16;
          cx = absv(pos_x) * m / span;
          cy = absv(pos_y) * m / span;
          acc_x = clip(acc_x - signed_as(pos_x, cx));
          acc_y = clip(acc_y - signed_as(pos_y, cy));
        end
        if (age != 65535) age++;
        if (age >= life) dead = 1;
      end
      w.pos_x = pos_x[31:0]; w.pos_y = pos_y[31:0];
      w.vel_x = vel_x[31:0]; w.vel_y = vel_y[31:0];
      w.expired = dead;
      pending = {pending, w};
    endfunction

    function void check_result(motion_word_t got);
      motion_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word pos=%0d,%0d", got.pos_x,
                                       got.pos_y);
        return;
      end
      want = pending.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
          got.expired !== want.expired) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp pos=%0d,%0d vel=%0d,%0d exp=%0b got pos=%0d,%0d vel=%0d,%0d exp=%0b",
                   want.pos_x, want.pos_y, want.vel_x, want.vel_y, want.expired,
                   got.pos_x, got.pos_y, got.vel_x, got.vel_y, got.expired);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [30:0] cfg_data = '0;

  pms_in_if in_ch();
  pms_out_if out_ch();

  particle_motion_step_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  particle_scoreboard sb = new();
  bit calm;       // no idling in the closing stretch
  int idle_cycles;
  localparam int STALL_LIMIT = 4000;

  // Sink side: random ready bursts, check every accepted word.
  always @(posedge clk) begin
    motion_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.pos_x = out_ch.pos_x; w.pos_y = out_ch.pos_y;
      w.vel_x = out_ch.vel_x; w.vel_y = out_ch.vel_y;
      w.expired = out_ch.expired;
      sb.check_result(w);
    end
  end

  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) out_ch.ready <= 1'b0;
      else if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(cfg_idx_t idx, logic [30:0] d);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  // Drain all expected words, then let the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(func_t f, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] vx, logic signed [31:0] vy,
                           logic [15:0] lf, logic signed [31:0] ux,
                           logic signed [31:0] uy);
    @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.func <= f;
    in_ch.spawn_pos_x <= px; in_ch.spawn_pos_y <= py;
    in_ch.spawn_vel_x <= vx; in_ch.spawn_vel_y <= vy;
    in_ch.spawn_life <= lf; in_ch.push_x <= ux; in_ch.push_y <= uy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f, px, py, vx, vy, lf, ux, uy);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      3: return 0;
      default: return $signed($urandom_range(0, 40000000)) - 20000000;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_push();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 0;
      default: return $signed($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(FUNC_SPAWN, rnd_q(), rnd_q(), rnd_q(), rnd_q(),
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
                  rnd_push(), rnd_push());
      else
        send_word(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                  rnd_push(), rnd_push());
    end
  endtask

  task automatic random_cfg();
    write_cfg(CFG_MAX_SPEED, $urandom_range(0, 3) == 0 ? 31'($urandom) :
              31'($urandom_range(0, 2000000)));
    write_cfg(CFG_MIN_SPEED, $urandom_range(0, 3) == 0 ? 31'($urandom) :
              31'($urandom_range(0, 200000)));
    write_cfg(CFG_DECAY_FACTOR, $urandom_range(0, 4) == 0 ? 31'($urandom_range(0, 131071)) :
              31'($urandom_range(50000, 65536)));
    write_cfg(CFG_PULL_RADIUS, $urandom_range(0, 3) == 0 ? 31'($urandom) :
              31'($urandom_range(0, 30000000)));
    write_cfg(CFG_PULL_STRENGTH, $urandom_range(0, 4) == 0 ? 31'($urandom_range(0, 131071)) :
              31'($urandom_range(0, 2000)));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_SPAWN;
    in_ch.spawn_pos_x = '0; in_ch.spawn_pos_y = '0;
    in_ch.spawn_vel_x = '0; in_ch.spawn_vel_y = '0;
    in_ch.spawn_life = '0; in_ch.push_x = '0; in_ch.push_y = '0;
    sb.reset_state();
    calm = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: spawn extremes, zero life, zero velocity, dead particle still moving.
    send_word(FUNC_SPAWN, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              16'hFFFF, 0, 0);
    send_word(FUNC_STEP, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
    send_word(FUNC_STEP, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF);
    send_word(FUNC_SPAWN, 0, 0, 0, 0, 16'd0, 0, 0);
    send_word(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, 16'hFFFF, 0, 0);
    send_word(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0);
    send_word(FUNC_SPAWN, 32'sd30000000, -32'sd30000000, 32'sd100, 32'sd0, 16'd2, 0, 0);
    repeat (4) send_word(FUNC_STEP, 0, 0, 0, 0, 0, 32'sd5000, -32'sd5000);
    send_word(FUNC_SPAWN, 32'sd65536, 32'sd0, 32'sd2000000, 32'sd2000000, 16'd3, 0, 0);
    repeat (3) send_word(FUNC_STEP, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Crossed limits, decay above one, strongest pull, zero radius.
    write_cfg(CFG_MAX_SPEED, 31'd1000);
    write_cfg(CFG_MIN_SPEED, 31'h7FFFFFFF);
    write_cfg(CFG_DECAY_FACTOR, 31'h1FFFF);
    write_cfg(CFG_PULL_RADIUS, 31'd0);
    write_cfg(CFG_PULL_STRENGTH, 31'h1FFFF);
    send_word(FUNC_SPAWN, 32'sd5000000, 32'sd7000000, 32'sd300, -32'sd300, 16'd5, 0, 0);
    repeat (4) send_word(FUNC_STEP, 0, 0, 0, 0, 0, 32'sd70000, 32'sd0);
    drain();
    write_cfg(CFG_MAX_SPEED, 31'h7FFFFFFF);
    write_cfg(CFG_MIN_SPEED, 31'd0);
    write_cfg(CFG_DECAY_FACTOR, 31'd0);
    write_cfg(CFG_PULL_RADIUS, 31'h7FFFFFFF);
    write_cfg(CFG_PULL_STRENGTH, 31'd0);
    send_word(FUNC_SPAWN, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              16'd1, 0, 0);
    repeat (3) send_word(FUNC_STEP, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000);
    drain();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 6; ph++) begin
      random_cfg();
      random_phase(300);
      drain();
    end
    calm = 1;
    random_phase(60);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
